FILE: hdl/binary_to_decimal_ascii_core_macros.svh
// Assertion helpers for the decimal text converter.
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge out of reset.
`define B2DA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("b2da assertion failed");

// Trigger implies consequence in the following cycle.
`define B2DA_ASSERT_NEXT(lbl, clk, rst_n, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("b2da assertion failed");

`else

`define B2DA_ASSERT(lbl, clk, rst_n, prop)
`define B2DA_ASSERT_NEXT(lbl, clk, rst_n, trig, cons)

`endif

`endif

FILE: hdl/b2da_pkg.sv
package b2da_pkg;

  localparam int BinW   = 32;
  localparam int DigitW = 4;
  localparam int DigitN = 10;
  localparam int BcdW   = DigitW * DigitN;
  localparam int CntW   = 5;
  localparam int RemW   = 4;
  localparam int CharW  = 6;

  localparam logic [CntW-1:0]  CntLast   = CntW'(BinW - 1);
  localparam logic [RemW-1:0]  RemInit   = RemW'(DigitN - 1);
  localparam logic [CharW-1:0] AsciiZero = 6'd48;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture new value, clear BCD
    logic shift;  // one double-dabble step
    logic skip;   // drop a leading zero digit
    logic emit;   // load top digit into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cnt_last;  // this shift is the final one
    logic top_zero;  // most significant remaining digit is zero
    logic rem_zero;  // only one digit remains
    logic out_free;  // output register can take a digit
  } stat_t;

endpackage

FILE: hdl/b2da_dp.sv
`include "binary_to_decimal_ascii_core_macros.svh"

module b2da_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  b2da_pkg::cmd_t             cmd_i,
  output b2da_pkg::stat_t            stat_o,
  input  logic [31:0]                value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [5:0]                 digit_char_o,
  output logic                       last_o
);
  import b2da_pkg::*;

  logic [BinW-1:0]   bin_q, bin_d;
  logic [BcdW-1:0]   bcd_q, bcd_d;
  logic [BcdW-1:0]   adj;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic              out_valid_q, out_valid_d;
  logic [CharW-1:0]  char_q, char_d;
  logic              last_q, last_d;
  logic [DigitW-1:0] top_digit;

  // add-3 correction on every digit, independent per digit
  always_comb begin
    for (int i = 0; i < DigitN; i++) begin
      if (bcd_q[DigitW*i +: DigitW] >= 4'd5) begin
        adj[DigitW*i +: DigitW] = bcd_q[DigitW*i +: DigitW] + 4'd3;
      end else begin
        adj[DigitW*i +: DigitW] = bcd_q[DigitW*i +: DigitW];
      end
    end
  end

  assign top_digit = bcd_q[BcdW-1 -: DigitW];

  // conversion registers next value
  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    rem_d = rem_q;
    if (cmd_i.load) begin
      bin_d = value_i;
      bcd_d = '0;
      cnt_d = '0;
      rem_d = RemInit;
    end else if (cmd_i.shift) begin
      bcd_d = {adj[BcdW-2:0], bin_q[BinW-1]};
      bin_d = {bin_q[BinW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
    end else if (cmd_i.skip || cmd_i.emit) begin
      bcd_d = {bcd_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
      rem_d = rem_q - 1'b1;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      char_d      = AsciiZero + {2'b00, top_digit};
      last_d      = (rem_q == '0);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign stat_o.cnt_last = (cnt_q == CntLast);
  assign stat_o.top_zero = (top_digit == '0);
  assign stat_o.rem_zero = (rem_q == '0);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = char_q;
  assign last_o       = last_q;

  // an emitted digit is always a decimal character
  `B2DA_ASSERT_NEXT(a_emit_char, clk_i, rst_ni, cmd_i.emit, (char_q - AsciiZero) <= 6'd9)
  // final digit flagged exactly when the count runs out
  `B2DA_ASSERT_NEXT(a_emit_last, clk_i, rst_ni, cmd_i.emit && (rem_q == '0), last_q)
  // the first shift starts from a cleared counter
  `B2DA_ASSERT_NEXT(a_load_cnt, clk_i, rst_ni, cmd_i.load, cnt_q == '0)

endmodule

FILE: hdl/b2da_ctrl.sv
`include "binary_to_decimal_ascii_core_macros.svh"

module b2da_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  b2da_pkg::stat_t stat_i,
  output b2da_pkg::cmd_t  cmd_o
);
  import b2da_pkg::*;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StConv = 4'b0010,
    StSkip = 4'b0100,
    StEmit = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // sequencing: convert, strip leading zeros, emit digits
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        ready_o = 1'b1;
        if (valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.shift = 1'b1;
        if (stat_i.cnt_last) begin
          state_d = StSkip;
        end
      end
      StSkip: begin
        if (stat_i.top_zero && !stat_i.rem_zero) begin
          cmd_o.skip = 1'b1;
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.rem_zero) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // never overwrite a digit still waiting at the output
  `B2DA_ASSERT(a_emit_free, clk_i, rst_ni, !cmd_o.emit || stat_i.out_free)
  // an accepted item starts conversion
  `B2DA_ASSERT_NEXT(a_accept_conv, clk_i, rst_ni, valid_i && ready_o, state_q == StConv)
  // after the last shift the zero stripping begins
  `B2DA_ASSERT_NEXT(a_conv_skip, clk_i, rst_ni, cmd_o.shift && stat_i.cnt_last, state_q == StSkip)
  // the last remaining digit is never stripped
  `B2DA_ASSERT(a_skip_keep, clk_i, rst_ni, !cmd_o.skip || !stat_i.rem_zero)

endmodule

FILE: hdl/binary_to_decimal_ascii_core.sv
// 32-bit binary to decimal ASCII text, one digit per result, most significant first.
// An item runs bit-serial double dabble over all 32 input bits, strips up to 9 leading
// zeros, takes one setup step, then gives one digit per cycle while the output is taken.
// A new item is accepted once the final digit is loaded into the output register.
// Reset (rst_ni low, asynchronous) returns the controller to idle and drops out_valid_o.
module binary_to_decimal_ascii_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  digit_char_o,
  output logic        last_o
);
  import b2da_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  b2da_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .ready_o (ready_o),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  // shift registers, BCD correction and output register
  b2da_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digit_char_o (digit_char_o),
    .last_o       (last_o)
  );

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import b2da_pkg::*;

  // One expected output item: an ASCII digit and the end-of-number flag
  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } dec_char_t;

  // Holds the decimal text still owed by the converter, oldest digit first
  class decimal_text_scoreboard;
    dec_char_t owed_q[$];
    int        errors;
    int        values_in;
    int        chars_out;
    int        len_seen[1:DigitN];

    // Split an accepted value into decimal digits, most significant first
    function void note_value(logic [BinW-1:0] v);
      logic [BinW-1:0] rest;
      logic [3:0]      msd_first[$];
      dec_char_t       c;
      rest = v;
      do begin
        msd_first.push_front(4'(rest % 10));
        rest = rest / 10;
      end while (rest != 0);
      foreach (msd_first[k]) begin
        c.ch   = AsciiZero + CharW'(msd_first[k]);
        c.last = (k == msd_first.size() - 1);
        owed_q.push_back(c);
      end
      len_seen[msd_first.size()]++;
      values_in++;
    endfunction

    // Compare one output item with the oldest owed digit
    function void check_char(logic [CharW-1:0] ch, logic last);
      dec_char_t want;
      chars_out++;
      if (owed_q.size() == 0) begin
        $error("unexpected output item: digit_char=%0d last=%0b", ch, last);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (ch !== want.ch) begin
        $error("digit_char mismatch: expected %0d, got %0d", want.ch, ch);
        errors++;
      end
      if (last !== want.last) begin
        $error("last mismatch: expected %0b, got %0b", want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             valid_i = 1'b0;
  logic [BinW-1:0]  value_i = '0;
  logic             out_ready_i = 1'b0;
  logic             ready_o;
  logic             out_valid_o;
  logic [CharW-1:0] digit_char_o;
  logic             last_o;

  decimal_text_scoreboard sb = new();
  logic calm = 1'b0;        // phase with no idling on either side
  bit   hold_done = 1'b0;

  binary_to_decimal_ascii_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .ready_o      (ready_o),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digit_char_o (digit_char_o),
    .last_o       (last_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Gap length: mostly none, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(99, 0);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Random value, biased toward every digit count and decade edges
  function automatic logic [BinW-1:0] pick_value();
    longint unsigned lo, hi, p;
    int              n, sel;
    sel = $urandom_range(9, 0);
    case (sel)
      0, 1, 2, 3: begin
        return $urandom();
      end
      4, 5, 6: begin
        n  = $urandom_range(DigitN, 1);
        lo = 1;
        for (int k = 1; k < n; k++) lo = lo * 10;
        hi = lo * 10 - 1;
        if (n == 1) lo = 0;
        if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
        return $urandom_range(32'(hi), 32'(lo));
      end
      7: begin
        p = 1;
        n = $urandom_range(DigitN - 1, 0);
        for (int k = 0; k < n; k++) p = p * 10;
        return 32'(p + $urandom_range(2, 0) - 1);
      end
      8: begin
        return 32'hFFFF_FFFF - $urandom_range(1000, 0);
      end
      default: begin
        return $urandom_range(20, 0);
      end
    endcase
  endfunction

  // Offer one item, holding it until the converter takes it
  task automatic send_value(input logic [BinW-1:0] v, input int gap);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (!ready_o);
    sb.note_value(v);
  endtask

  // Stop sending until every owed digit has come out
  task automatic drain();
    valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Output side: random stalls, plus one long hold-off while input keeps coming
  initial begin
    int burst, stall;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!hold_done && sb.values_in >= 80) begin
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_done = 1'b1;
      end
      burst = $urandom_range(20, 1);
      out_ready_i <= 1'b1;
      repeat (burst) @(posedge clk_i);
      stall = idle_len();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // Output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_char(digit_char_o, last_o);
    end
  end

  // Stimulus and end of run
  initial begin
    logic [BinW-1:0] edge_vals[$];
    edge_vals = '{0, 1, 9, 10, 99, 100, 999, 1000, 9999, 10000, 99999, 100000,
                  999999, 1000000, 9999999, 10000000, 99999999, 100000000,
                  999999999, 1000000000, 1234567890, 32'h8000_0000,
                  32'hFFFF_FFFE, 32'hFFFF_FFFF};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero, decade edges, largest value, all bits high and low
    foreach (edge_vals[i]) send_value(edge_vals[i], idle_len());
    drain();

    // Random: alternating calm and idling phases, with one full drain midway
    for (int i = 0; i < 430; i++) begin
      if (i % 50 == 0) calm = (i % 100 == 50);
      if (i == 250) drain();
      send_value(pick_value(), idle_len());
    end
    valid_i <= 1'b0;

    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (60) @(posedge clk_i);

    $display("converted %0d values (%0d with ten digits, %0d single digit)",
             sb.values_in, sb.len_seen[DigitN], sb.len_seen[1]);
    $display("checked %0d digit characters, long output hold-off %0s",
             sb.chars_out, hold_done ? "done" : "not reached");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
